### rtl/gbc_pkg.sv
`default_nettype none
package gbc_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int COUNT_BITS_DEF  = 10;

	localparam int LIMIT_BITS   = 15;
	localparam int TARGET_BITS  = 10;
	localparam int TIME_BITS    = 16;
	localparam int REJ_BITS     = 16;
	localparam int CFG_BITS     = 16;
	localparam int CFG_IDX_BITS = 2;
	localparam int KIND_BITS    = 2;

	localparam logic [LIMIT_BITS-1:0]  LIMIT_RST   = LIMIT_BITS'(229);
	localparam logic [TARGET_BITS-1:0] TARGET_RST  = TARGET_BITS'(300);
	localparam logic [TIME_BITS-1:0]   TIMEOUT_RST = TIME_BITS'(5000);
	localparam logic [TIME_BITS-1:0]   SETTLE_RST  = TIME_BITS'(300);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_STILL_LIMIT  = 2'd0,
		REG_TARGET_COUNT = 2'd1,
		REG_TIMEOUT      = 2'd2,
		REG_SETTLE       = 2'd3
	} cfg_reg_t;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_START  = 2'd0,
		KIND_SAMPLE = 2'd1,
		KIND_TICK   = 2'd2
	} kind_t;

	localparam logic REPORT_CAL    = 1'b0;
	localparam logic REPORT_SAMPLE = 1'b1;

	typedef struct packed {
		logic clear;
		logic tick_inc;
		logic tick_clr;
		logic accum;
		logic reject;
		logic div_start;
		logic emit_sample;
		logic emit_report;
	} gbc_cmd_t;

	typedef struct packed {
		logic settle_zero;
		logic settle_hit;
		logic timeout_hit;
		logic still;
		logic target_hit;
		logic div_done;
	} gbc_stat_t;

endpackage
`default_nettype wire

### rtl/gbc_in_if.sv
`default_nettype none
interface gbc_in_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic [1:0]                    kind;
	logic signed [SAMPLE_BITS-1:0] rate_x;
	logic signed [SAMPLE_BITS-1:0] rate_y;
	logic signed [SAMPLE_BITS-1:0] rate_z;

	modport source (output valid, kind, rate_x, rate_y, rate_z, input ready);
	modport sink (input valid, kind, rate_x, rate_y, rate_z, output ready);
endinterface
`default_nettype wire

### rtl/gbc_out_if.sv
`default_nettype none
interface gbc_out_if #(
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 10
);
	logic                          valid;
	logic                          ready;
	logic                          report_kind;
	logic signed [SAMPLE_BITS-1:0] value_x;
	logic signed [SAMPLE_BITS-1:0] value_y;
	logic signed [SAMPLE_BITS-1:0] value_z;
	logic [COUNT_BITS-1:0]         accepted_count;
	logic [15:0]                   rejected_count;
	logic                          bias_valid;

	modport source (output valid, report_kind, value_x, value_y, value_z,
		accepted_count, rejected_count, bias_valid, input ready);
	modport sink (input valid, report_kind, value_x, value_y, value_z,
		accepted_count, rejected_count, bias_valid, output ready);
endinterface
`default_nettype wire

### rtl/gbc_ctrl.sv
`default_nettype none
module gbc_ctrl
	import gbc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic [KIND_BITS-1:0] kind,
	input  wire logic                 q_full,
	input  wire gbc_stat_t            st,
	output logic                      in_ready,
	output gbc_cmd_t                  cmd
);

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_SETTLE  = 6'b000010,
		ST_COLLECT = 6'b000100,
		ST_PREP    = 6'b001000,
		ST_DIVIDE  = 6'b010000,
		ST_REPORT  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		accept   = 1'b0;
		unique case (state_q)
			ST_IDLE, ST_SETTLE, ST_COLLECT: begin
				in_ready = !q_full;
				accept   = in_valid && !q_full;
				if (accept) begin
					unique case (kind)
						KIND_START: begin
							cmd.clear = 1'b1;
							state_d   = st.settle_zero ? ST_COLLECT : ST_SETTLE;
						end
						KIND_TICK: begin
							if (state_q == ST_SETTLE) begin
								if (st.settle_hit) begin
									cmd.tick_clr = 1'b1;
									state_d      = ST_COLLECT;
								end else begin
									cmd.tick_inc = 1'b1;
								end
							end else if (state_q == ST_COLLECT) begin
								if (st.timeout_hit) begin
									state_d = ST_PREP;
								end else begin
									cmd.tick_inc = 1'b1;
								end
							end
						end
						KIND_SAMPLE: begin
							if (state_q == ST_IDLE) begin
								cmd.emit_sample = 1'b1;
							end else if (state_q == ST_COLLECT) begin
								if (!st.still) begin
									cmd.reject = 1'b1;
								end else begin
									cmd.accum = 1'b1;
									if (st.target_hit) begin
										state_d = ST_PREP;
									end
								end
							end
						end
						default: ;
					endcase
				end
			end
			ST_PREP: begin
				cmd.div_start = 1'b1;
				cmd.tick_clr  = 1'b1;
				state_d       = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (st.div_done) begin
					state_d = ST_REPORT;
				end
			end
			ST_REPORT: begin
				cmd.emit_report = 1'b1;
				state_d         = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_done_in_divide: assert property (@(posedge clk) disable iff (!arst_n)
		st.div_done |-> state_q == ST_DIVIDE)
		else $error("divider finished outside the divide state");
	a_report_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_REPORT |-> $past(st.div_done))
		else $error("report issued without a finished division");
`endif

endmodule
`default_nettype wire

### rtl/gbc_dpath.sv
`default_nettype none
module gbc_dpath
	import gbc_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [CFG_IDX_BITS-1:0]       wr_index,
	input  wire logic [CFG_BITS-1:0]           wr_data,
	input  wire logic signed [SAMPLE_BITS-1:0] rate_x,
	input  wire logic signed [SAMPLE_BITS-1:0] rate_y,
	input  wire logic signed [SAMPLE_BITS-1:0] rate_z,
	input  wire gbc_cmd_t                      cmd,
	output gbc_stat_t                          st,
	output logic                               res_report_kind,
	output logic signed [SAMPLE_BITS-1:0]      res_x,
	output logic signed [SAMPLE_BITS-1:0]      res_y,
	output logic signed [SAMPLE_BITS-1:0]      res_z,
	output logic [COUNT_BITS-1:0]              res_acc,
	output logic [REJ_BITS-1:0]                res_rej,
	output logic                               res_valid
);

	localparam int SUM_BITS  = SAMPLE_BITS + COUNT_BITS;
	localparam int CMP_BITS  = (SAMPLE_BITS > LIMIT_BITS) ? SAMPLE_BITS : LIMIT_BITS;
	localparam int TGT_BITS  = ((COUNT_BITS > TARGET_BITS) ? COUNT_BITS : TARGET_BITS) + 2;
	localparam int STEP_BITS = $clog2(SUM_BITS);

	localparam logic [COUNT_BITS-1:0]       ACC_MAX  = {COUNT_BITS{1'b1}};
	localparam logic [REJ_BITS-1:0]         REJ_MAX  = {REJ_BITS{1'b1}};
	localparam logic [STEP_BITS-1:0]        STEP_END = STEP_BITS'(SUM_BITS - 1);
	localparam logic signed [SAMPLE_BITS-1:0] VAL_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] VAL_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [SUM_BITS-1:0]         HALF     = SUM_BITS'(1) << (SAMPLE_BITS - 1);

	logic [LIMIT_BITS-1:0]  still_limit_q;
	logic [TARGET_BITS-1:0] target_q;
	logic [TIME_BITS-1:0]   timeout_q;
	logic [TIME_BITS-1:0]   settle_q;

	logic [TIME_BITS-1:0]          tick_q;
	logic signed [SUM_BITS-1:0]    sums_q [3];
	logic [COUNT_BITS-1:0]         acc_q;
	logic [REJ_BITS-1:0]           rej_q;
	logic signed [SAMPLE_BITS-1:0] bias_q [3];
	logic                          valid_q;

	logic                   busy_q;
	logic [1:0]             ax_q;
	logic [STEP_BITS-1:0]   step_q;
	logic [SUM_BITS-1:0]    dq_q;
	logic [COUNT_BITS-1:0]  rem_q;
	logic                   neg_q;

	logic signed [SAMPLE_BITS-1:0] rate [3];
	logic [SAMPLE_BITS-1:0]        mag [3];
	logic signed [SAMPLE_BITS-1:0] corr [3];
	logic [2:0]                    axis_still;
	logic [TIME_BITS-1:0]          tick_n;
	logic [COUNT_BITS-1:0]         acc_n;
	logic [TGT_BITS-1:0]           thr;

	logic [1:0]                    load_ax;
	logic signed [SUM_BITS-1:0]    load_sum;
	logic                          load_neg;
	logic [SUM_BITS-1:0]           load_dq;
	logic [COUNT_BITS:0]           rem_sh;
	logic                          q_bit;
	logic [COUNT_BITS-1:0]         rem_n;
	logic [SUM_BITS-1:0]           dq_n;
	logic signed [SAMPLE_BITS-1:0] bias_new;
	logic                          last_step;

	assign rate[0] = rate_x;
	assign rate[1] = rate_y;
	assign rate[2] = rate_z;

	always_comb begin
		logic signed [SAMPLE_BITS:0] diff;
		for (int i = 0; i < 3; i++) begin
			mag[i] = rate[i][SAMPLE_BITS-1] ? SAMPLE_BITS'(-rate[i]) : SAMPLE_BITS'(rate[i]);
			axis_still[i] = CMP_BITS'(mag[i]) <= CMP_BITS'(still_limit_q);
			diff = (SAMPLE_BITS+1)'(rate[i]) - (SAMPLE_BITS+1)'(bias_q[i]);
			if (diff[SAMPLE_BITS] != diff[SAMPLE_BITS-1]) begin
				corr[i] = diff[SAMPLE_BITS] ? VAL_MIN : VAL_MAX;
			end else begin
				corr[i] = diff[SAMPLE_BITS-1:0];
			end
		end
	end

	assign tick_n = tick_q + TIME_BITS'(1);
	assign acc_n  = (acc_q == ACC_MAX) ? acc_q : acc_q + COUNT_BITS'(1);
	assign thr    = (TGT_BITS'(acc_q) << 1) + TGT_BITS'(acc_q) + TGT_BITS'(2);

	// restoring divider, one quotient bit a cycle
	assign load_ax  = cmd.div_start ? 2'd0 : ax_q + 2'd1;
	assign load_sum = sums_q[load_ax];
	assign load_neg = load_sum[SUM_BITS-1];
	assign load_dq  = (load_neg ? SUM_BITS'(-load_sum) : SUM_BITS'(load_sum))
		+ SUM_BITS'(acc_q >> 1);
	assign rem_sh   = {rem_q, dq_q[SUM_BITS-1]};
	assign q_bit    = rem_sh >= {1'b0, acc_q};
	assign rem_n    = q_bit ? COUNT_BITS'(rem_sh - {1'b0, acc_q}) : rem_sh[COUNT_BITS-1:0];
	assign dq_n     = {dq_q[SUM_BITS-2:0], q_bit};
	assign last_step = busy_q && step_q == STEP_END;

	always_comb begin
		if (!valid_q) begin
			bias_new = '0;
		end else if (!neg_q) begin
			bias_new = (|dq_n[SUM_BITS-1:SAMPLE_BITS-1]) ? VAL_MAX : dq_n[SAMPLE_BITS-1:0];
		end else begin
			bias_new = (dq_n > HALF) ? VAL_MIN : SAMPLE_BITS'(-dq_n[SAMPLE_BITS-1:0]);
		end
	end

	always_comb begin
		st.settle_zero = settle_q == '0;
		st.settle_hit  = tick_n >= settle_q;
		st.timeout_hit = tick_n >= timeout_q;
		st.still       = &axis_still;
		st.target_hit  = (TGT_BITS'(acc_n) >= TGT_BITS'(target_q)) || (acc_n == ACC_MAX);
		st.div_done    = last_step && ax_q == 2'd2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			still_limit_q <= LIMIT_RST;
			target_q      <= TARGET_RST;
			timeout_q     <= TIMEOUT_RST;
			settle_q      <= SETTLE_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_STILL_LIMIT:  still_limit_q <= wr_data[LIMIT_BITS-1:0];
				REG_TARGET_COUNT: target_q      <= wr_data[TARGET_BITS-1:0];
				REG_TIMEOUT:      timeout_q     <= wr_data[TIME_BITS-1:0];
				REG_SETTLE:       settle_q      <= wr_data[TIME_BITS-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			acc_q   <= '0;
			rej_q   <= '0;
			valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				sums_q[i] <= '0;
				bias_q[i] <= '0;
			end
		end else begin
			if (cmd.clear || cmd.tick_clr) begin
				tick_q <= '0;
			end else if (cmd.tick_inc) begin
				tick_q <= tick_n;
			end
			if (cmd.clear) begin
				acc_q <= '0;
				rej_q <= '0;
				for (int i = 0; i < 3; i++) begin
					sums_q[i] <= '0;
				end
			end else begin
				if (cmd.accum && acc_q != ACC_MAX) begin
					acc_q <= acc_n;
					for (int i = 0; i < 3; i++) begin
						sums_q[i] <= sums_q[i] + SUM_BITS'(rate[i]);
					end
				end
				if (cmd.reject && rej_q != REJ_MAX) begin
					rej_q <= rej_q + REJ_BITS'(1);
				end
			end
			if (cmd.div_start) begin
				valid_q <= (acc_q != '0) && (thr >= TGT_BITS'(target_q));
			end
			if (last_step) begin
				bias_q[ax_q] <= bias_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ax_q   <= '0;
			step_q <= '0;
		end else if (cmd.div_start) begin
			busy_q <= 1'b1;
			ax_q   <= '0;
			step_q <= '0;
		end else if (busy_q) begin
			if (last_step) begin
				step_q <= '0;
				if (ax_q == 2'd2) begin
					busy_q <= 1'b0;
				end else begin
					ax_q <= load_ax;
				end
			end else begin
				step_q <= step_q + STEP_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start || (last_step && ax_q != 2'd2)) begin
			dq_q  <= load_dq;
			rem_q <= '0;
			neg_q <= load_neg;
		end else if (busy_q) begin
			dq_q  <= dq_n;
			rem_q <= rem_n;
		end
	end

	always_comb begin
		res_report_kind = cmd.emit_report ? REPORT_CAL : REPORT_SAMPLE;
		if (cmd.emit_report) begin
			res_x = bias_q[0];
			res_y = bias_q[1];
			res_z = bias_q[2];
		end else begin
			res_x = corr[0];
			res_y = corr[1];
			res_z = corr[2];
		end
		res_acc   = acc_q;
		res_rej   = rej_q;
		res_valid = valid_q;
	end

endmodule
`default_nettype wire

### rtl/gbc_outq.sv
`default_nettype none
module gbc_outq #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	output logic              full,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [W-1:0]      out_data
);

	logic         v0_q, v1_q, v0_d, v1_d, pop;
	logic [W-1:0] head_q, skid_q, head_d, skid_d;

	assign pop       = v0_q && out_ready;
	assign full      = v1_q;
	assign out_valid = v0_q;
	assign out_data  = head_q;

	always_comb begin
		v0_d   = v0_q;
		v1_d   = v1_q;
		head_d = head_q;
		skid_d = skid_q;
		if (pop) begin
			head_d = skid_q;
			v0_d   = v1_q;
			v1_d   = 1'b0;
		end
		if (push) begin
			if (!v0_d) begin
				head_d = push_data;
				v0_d   = 1'b1;
			end else begin
				skid_d = push_data;
				v1_d   = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else begin
			v0_q <= v0_d;
			v1_q <= v1_d;
		end
	end

	always_ff @(posedge clk) begin
		head_q <= head_d;
		skid_q <= skid_d;
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !v1_q)
		else $error("result pushed into a full queue");
	a_skid_behind_head: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q |-> v0_q)
		else $error("skid entry held without a head entry");
`endif

endmodule
`default_nettype wire

### rtl/gyro_bias_calibrator.sv
`default_nettype none
// Zero-rate bias calibration and correction for a three-axis gyro. Items on the
// input channel are a start, a raw sample or a millisecond tick; the input is
// ready unless the output queue is full or a calibration is ending. A start
// waits settle_ms ticks, then averages still samples until target_count are
// gathered or timeout_ms ticks pass, and reports the biases. Outside calibration
// each sample comes back with the bias removed, saturated. Ending a calibration
// holds the input off while the three averages go through one shared restoring
// divider that yields one quotient bit per cycle. Results leave through a
// two-entry output queue, so input items keep flowing while one result waits.
module gyro_bias_calibrator
	import gbc_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    wr_en,
	input  wire logic [CFG_IDX_BITS-1:0] wr_index,
	input  wire logic [CFG_BITS-1:0]     wr_data,
	gbc_in_if.sink                       samples,
	gbc_out_if.source                    results
);

	localparam int RES_BITS = 1 + 3 * SAMPLE_BITS + COUNT_BITS + REJ_BITS + 1;

	gbc_cmd_t  cmd;
	gbc_stat_t st;
	logic      q_full;
	logic      push;

	logic                          res_report_kind;
	logic signed [SAMPLE_BITS-1:0] res_x, res_y, res_z;
	logic [COUNT_BITS-1:0]         res_acc;
	logic [REJ_BITS-1:0]           res_rej;
	logic                          res_valid;
	logic [RES_BITS-1:0]           q_data;

	gbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.kind     (samples.kind),
		.q_full   (q_full),
		.st       (st),
		.in_ready (samples.ready),
		.cmd      (cmd)
	);

	gbc_dpath #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.rate_x          (samples.rate_x),
		.rate_y          (samples.rate_y),
		.rate_z          (samples.rate_z),
		.cmd             (cmd),
		.st              (st),
		.res_report_kind (res_report_kind),
		.res_x           (res_x),
		.res_y           (res_y),
		.res_z           (res_z),
		.res_acc         (res_acc),
		.res_rej         (res_rej),
		.res_valid       (res_valid)
	);

	assign push = cmd.emit_sample || cmd.emit_report;

	gbc_outq #(
		.W (RES_BITS)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({res_report_kind, res_x, res_y, res_z, res_acc, res_rej, res_valid}),
		.full      (q_full),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.out_data  (q_data)
	);

	assign {results.report_kind, results.value_x, results.value_y, results.value_z,
		results.accepted_count, results.rejected_count, results.bias_valid} = q_data;

endmodule
`default_nettype wire

### verif/tb.sv
`timescale 1ns / 100ps
module tb;
	import gbc_pkg::*;

	localparam logic [KIND_BITS-1:0] KIND_SPARE = 2'd3;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 120;
	localparam int RANDOM_ITEMS = 350;

	typedef enum logic [1:0] {CAL_IDLE, CAL_SETTLE, CAL_COLLECT} cal_phase_t;

	typedef struct packed {
		logic [KIND_BITS-1:0] kind;
		logic signed [15:0]   x;
		logic signed [15:0]   y;
		logic signed [15:0]   z;
	} gyro_item_t;

	typedef struct packed {
		logic               report_kind;
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic signed [15:0] vz;
		logic [9:0]         acc;
		logic [15:0]        rej;
		logic               ok;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	logic [CFG_IDX_BITS-1:0] wr_index;
	logic [CFG_BITS-1:0] wr_data;

	gbc_in_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) in_ch ();
	gbc_out_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF), .COUNT_BITS(COUNT_BITS_DEF)) out_ch ();

	gyro_bias_calibrator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.samples  (in_ch),
		.results  (out_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predicted block state
	logic [14:0]        cfg_still;
	logic [9:0]         cfg_target;
	logic [15:0]        cfg_timeout;
	logic [15:0]        cfg_settle;
	cal_phase_t         cal_phase;
	logic [15:0]        tick_cnt;
	longint             axis_sum [3];
	logic [9:0]         n_still;
	logic [15:0]        n_moving;
	logic signed [15:0] bias [3];
	logic               bias_ok;

	gyro_item_t pending [$];
	reading_t   due_readings [$];
	reading_t   head;
	int         errors = 0;
	int         random_count = 0;
	int         holds_asked = 0;
	int         holds_done = 0;
	int         hold_left = 0;
	int         mode_left = 0;
	int         ready_mode = 0;
	int         burst_left = 1;
	int         gap_left = 0;
	bit         in_fire = 1'b0;

	function automatic logic signed [15:0] clamp16(longint v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	task automatic emit(logic rk, logic signed [15:0] a, logic signed [15:0] b,
		logic signed [15:0] c);
		reading_t r;
		r.report_kind = rk;
		r.vx = a;
		r.vy = b;
		r.vz = c;
		r.acc = n_still;
		r.rej = n_moving;
		r.ok = bias_ok;
		due_readings.push_back(r);
	endtask

	task automatic close_calibration();
		longint cnt, mag, q;
		cnt = longint'(n_still);
		bias_ok = (n_still != 0) && (n_still >= cfg_target / 3);
		for (int i = 0; i < 3; i++) begin
			if (bias_ok) begin
				mag = axis_sum[i] < 0 ? -axis_sum[i] : axis_sum[i];
				q = (mag + cnt / 2) / cnt;
				bias[i] = clamp16(axis_sum[i] < 0 ? -q : q);
			end else begin
				bias[i] = '0;
			end
		end
		cal_phase = CAL_IDLE;
		tick_cnt = '0;
		emit(REPORT_CAL, bias[0], bias[1], bias[2]);
	endtask

	task automatic track_calibration(gyro_item_t it);
		longint raw [3];
		bit still;
		raw[0] = longint'($signed(it.x));
		raw[1] = longint'($signed(it.y));
		raw[2] = longint'($signed(it.z));
		case (it.kind)
			KIND_START: begin
				for (int i = 0; i < 3; i++)
					axis_sum[i] = 0;
				n_still = '0;
				n_moving = '0;
				tick_cnt = '0;
				cal_phase = (cfg_settle == 0) ? CAL_COLLECT : CAL_SETTLE;
			end
			KIND_TICK: begin
				if (cal_phase == CAL_SETTLE) begin
					tick_cnt = tick_cnt + 16'd1;
					if (tick_cnt >= cfg_settle) begin
						cal_phase = CAL_COLLECT;
						tick_cnt = '0;
					end
				end else if (cal_phase == CAL_COLLECT) begin
					tick_cnt = tick_cnt + 16'd1;
					if (tick_cnt >= cfg_timeout)
						close_calibration();
				end
			end
			KIND_SAMPLE: begin
				if (cal_phase == CAL_IDLE) begin
					emit(REPORT_SAMPLE, clamp16(raw[0] - longint'(bias[0])),
						clamp16(raw[1] - longint'(bias[1])),
						clamp16(raw[2] - longint'(bias[2])));
				end else if (cal_phase == CAL_COLLECT) begin
					still = 1'b1;
					for (int i = 0; i < 3; i++)
						if ((raw[i] < 0 ? -raw[i] : raw[i]) > longint'(cfg_still))
							still = 1'b0;
					if (!still) begin
						if (n_moving != 16'hffff)
							n_moving = n_moving + 16'd1;
					end else begin
						if (n_still != 10'd1023) begin
							for (int i = 0; i < 3; i++)
								axis_sum[i] += raw[i];
							n_still = n_still + 10'd1;
						end
						if (n_still >= cfg_target || n_still == 10'd1023)
							close_calibration();
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic add(logic [KIND_BITS-1:0] kind, logic [15:0] x, logic [15:0] y,
		logic [15:0] z);
		gyro_item_t it;
		it.kind = kind;
		it.x = x;
		it.y = y;
		it.z = z;
		if (kind == KIND_SAMPLE || kind == KIND_START
			|| (kind == KIND_TICK && cal_phase != CAL_IDLE))
			random_count++;
		pending.push_back(it);
		track_calibration(it);
	endtask

	function automatic logic [15:0] any16();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] still16();
		int lim, v;
		lim = int'(cfg_still);
		case ($urandom_range(0, 7))
			0: v = lim;
			1: v = -lim;
			default: v = int'($urandom_range(0, 2 * lim)) - lim;
		endcase
		return 16'(v);
	endfunction

	function automatic logic [15:0] moving16();
		int lim, v;
		lim = int'(cfg_still);
		if (lim == 32767)
			return 16'h8000;
		v = int'($urandom_range(lim + 1, 32768));
		if ($urandom_range(0, 1))
			v = -v;
		return 16'(v);
	endfunction

	task automatic add_moving();
		int a;
		a = $urandom_range(0, 2);
		add(KIND_SAMPLE, a == 0 ? moving16() : still16(), a == 1 ? moving16() : still16(),
			a == 2 ? moving16() : still16());
	endtask

	// start, then random traffic, spare kinds included, until the calibration reports
	task automatic run_calibration(int settle_tick_pct, bit restarts);
		int pick;
		add(KIND_START, any16(), any16(), any16());
		while (cal_phase != CAL_IDLE) begin
			pick = $urandom_range(0, 99);
			if (cal_phase == CAL_SETTLE) begin
				if (pick < settle_tick_pct)
					add(KIND_TICK, any16(), any16(), any16());
				else if (pick < settle_tick_pct + 2)
					add(KIND_SPARE, any16(), any16(), any16());
				else
					add(KIND_SAMPLE, any16(), any16(), any16());
			end else begin
				if (pick < 55)
					add(KIND_SAMPLE, still16(), still16(), still16());
				else if (pick < 72)
					add_moving();
				else if (pick < 92)
					add(KIND_TICK, any16(), any16(), any16());
				else if (pick < 95)
					add(KIND_SAMPLE, any16(), any16(), any16());
				else if (pick < 97 && restarts)
					add(KIND_START, any16(), any16(), any16());
				else
					add(KIND_SPARE, any16(), any16(), any16());
			end
		end
	endtask

	task automatic run_idle(int n);
		int pick;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				add(KIND_SAMPLE, any16(), any16(), any16());
			else if (pick < 82)
				add(KIND_TICK, any16(), any16(), any16());
			else if (pick < 92)
				add(KIND_SPARE, any16(), any16(), any16());
			else
				add(KIND_SAMPLE, still16(), still16(), still16());
		end
	endtask

	task automatic drain();
		while (pending.size() != 0 || due_readings.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, int val);
		@(negedge clk);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = CFG_BITS'(val);
		case (idx)
			REG_STILL_LIMIT:  cfg_still = LIMIT_BITS'(val);
			REG_TARGET_COUNT: cfg_target = TARGET_BITS'(val);
			REG_TIMEOUT:      cfg_timeout = TIME_BITS'(val);
			REG_SETTLE:       cfg_settle = TIME_BITS'(val);
			default: ;
		endcase
	endtask

	task automatic configure(int lim, int tgt, int tmo, int stl);
		drain();
		write_reg(REG_STILL_LIMIT, lim);
		write_reg(REG_TARGET_COUNT, tgt);
		write_reg(REG_TIMEOUT, tmo);
		write_reg(REG_SETTLE, stl);
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	task automatic check_field(string name, logic signed [31:0] want,
		logic signed [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			in_fire = 1'b0;
		end else begin
			in_fire = in_ch.valid && in_ch.ready;
			if (out_ch.valid && out_ch.ready) begin
				if (due_readings.size() == 0) begin
					$error("unexpected transaction: report_kind %0d", out_ch.report_kind);
					errors++;
				end else begin
					head = due_readings.pop_front();
					check_field("report_kind", head.report_kind, out_ch.report_kind);
					check_field("value_x", head.vx, out_ch.value_x);
					check_field("value_y", head.vy, out_ch.value_y);
					check_field("value_z", head.vz, out_ch.value_z);
					check_field("accepted_count", head.acc, out_ch.accepted_count);
					check_field("rejected_count", head.rej, out_ch.rejected_count);
					check_field("bias_valid", head.ok, out_ch.bias_valid);
				end
			end
		end
	end

	// driver: bursts with gaps, valid held until the transaction completes
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_fire) begin
				void'(pending.pop_front());
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
			if (gap_left > 0 && !(in_ch.valid && !in_fire)) begin
				gap_left--;
				in_ch.valid <= 1'b0;
			end else if (pending.size() != 0) begin
				in_ch.valid <= 1'b1;
				in_ch.kind <= pending[0].kind;
				in_ch.rate_x <= pending[0].x;
				in_ch.rate_y <= pending[0].y;
				in_ch.rate_z <= pending[0].z;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (holds_done != holds_asked) begin
				holds_done++;
				hold_left = HOLD_CYCLES - 1;
				out_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					ready_mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (ready_mode)
					0: out_ch.ready <= 1'b1;
					1: out_ch.ready <= 1'($urandom_range(0, 1));
					2: out_ch.ready <= ($urandom_range(0, 3) == 0);
					default: out_ch.ready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int lim, tgt, tmo, stl;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_STILL_LIMIT;
		wr_data = '0;
		in_ch.valid = 1'b0;
		in_ch.kind = KIND_START;
		in_ch.rate_x = '0;
		in_ch.rate_y = '0;
		in_ch.rate_z = '0;
		out_ch.ready = 1'b0;
		cfg_still = LIMIT_RST;
		cfg_target = TARGET_RST;
		cfg_timeout = TIMEOUT_RST;
		cfg_settle = SETTLE_RST;
		cal_phase = CAL_IDLE;
		tick_cnt = '0;
		n_still = '0;
		n_moving = '0;
		bias_ok = 1'b0;
		for (int i = 0; i < 3; i++) begin
			axis_sum[i] = 0;
			bias[i] = '0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// pass-through at zero bias, idle tick, spare kind, then reset settings
		add(KIND_SAMPLE, 16'h7fff, 16'h8000, 16'h0000);
		add(KIND_SAMPLE, 16'hffff, 16'h0001, 16'h8000);
		add(KIND_TICK, 16'h1234, 16'h8000, 16'h7fff);
		add(KIND_SPARE, 16'hffff, 16'hffff, 16'hffff);
		run_calibration(97, 1'b0);

		// no settle, single-tick timeout, biases at full scale, saturating correction
		configure(32767, 3, 1, 0);
		add(KIND_START, 16'h0000, 16'h0000, 16'h0000);
		add(KIND_SAMPLE, 16'h7fff, 16'h8001, 16'd100);
		add(KIND_SAMPLE, 16'h8000, 16'h0000, 16'h0000);
		add(KIND_TICK, 16'h0000, 16'h0000, 16'h0000);
		add(KIND_SAMPLE, 16'h8000, 16'h7fff, 16'd100);
		add(KIND_SAMPLE, 16'h7fff, 16'h8000, 16'h0000);

		// zero limit, zero target, zero timeout, restart while settling
		configure(0, 0, 0, 2);
		add(KIND_START, 16'h0000, 16'h0000, 16'h0000);
		add(KIND_SAMPLE, 16'd5, 16'd5, 16'd5);
		add(KIND_TICK, 16'h0000, 16'h0000, 16'h0000);
		add(KIND_START, 16'h0000, 16'h0000, 16'h0000);
		add(KIND_TICK, 16'h0000, 16'h0000, 16'h0000);
		add(KIND_TICK, 16'h0000, 16'h0000, 16'h0000);
		add(KIND_SAMPLE, 16'h0000, 16'h0000, 16'h0001);
		add(KIND_SAMPLE, 16'h0000, 16'h0000, 16'h0000);
		add(KIND_START, 16'h0000, 16'h0000, 16'h0000);
		add(KIND_TICK, 16'h0000, 16'h0000, 16'h0000);
		add(KIND_TICK, 16'h0000, 16'h0000, 16'h0000);
		add(KIND_TICK, 16'h0000, 16'h0000, 16'h0000);
		add(KIND_SAMPLE, 16'h8000, 16'h7fff, 16'h0001);

		random_count = 0;
		while (random_count < RANDOM_ITEMS) begin
			case ($urandom_range(0, 3))
				0: lim = 0;
				1: lim = 32767;
				2: lim = $urandom_range(1, 32766);
				default: lim = $urandom_range(1, 400);
			endcase
			case ($urandom_range(0, 5))
				0: tgt = $urandom_range(0, 2);
				1: tgt = 3;
				default: tgt = $urandom_range(3, 40);
			endcase
			case ($urandom_range(0, 4))
				0: tmo = 0;
				1: tmo = 1;
				default: tmo = $urandom_range(2, 80);
			endcase
			stl = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			configure(lim, tgt, tmo, stl);
			if (holds_asked == 0) begin
				holds_asked++;
				run_idle(60);
			end
			run_idle($urandom_range(5, 30));
			repeat ($urandom_range(1, 3)) begin
				run_calibration(50, 1'b1);
				run_idle($urandom_range(3, 20));
			end
		end

		configure(32767, 40, 65535, 0);
		run_calibration(50, 1'b0);
		run_idle(30);
		configure(int'(LIMIT_RST), 3, 65535, 20);
		run_calibration(97, 1'b0);
		run_idle(30);
		drain();

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
